@@ rtl/debye_pkg.sv @@
// Shared constants for the Debye permittivity evaluator: table size, field
// widths, fixed-point limits, operation and register codes.
// No dependencies.
`default_nettype none

package debye_pkg;

  // Pole table
  localparam int POLES   = 8;
  localparam int POLE_IW = $clog2(POLES);
  localparam int CNT_W   = $clog2(POLES + 1);

  // Field widths
  localparam int PERM_W  = 31;   // unsigned Q7.24 permittivity
  localparam int TIME_W  = 32;
  localparam int FREQ_W  = 32;
  localparam int OUT_W   = 32;
  localparam int ACT_W   = 4;
  localparam int CFG_W   = 31;

  // Pole evaluation widths
  localparam int X_W     = 40;   // (freq * tau) >> 24
  localparam int MW_W    = 32;   // scaled max(x, 1.0) >> 8
  localparam int AB_W    = 17;   // a, b after normalization, <= 65536
  localparam int SQ_W    = 33;   // a*a, a*b, b*b
  localparam int DEN_W   = 34;   // a*a + b*b
  localparam int Q_W     = 31;   // Q0.30 ratio, up to 1.0
  localparam int TERM_W  = 32;
  localparam int SUM_W   = 38;

  // Fixed-point constants
  localparam logic [X_W-1:0]  Q24_ONE     = X_W'(24'hFFFFFF) + X_W'(1);
  localparam logic [MW_W-1:0] SCALE_LIMIT = MW_W'(65536);
  localparam logic [AB_W-1:0] A_START     = AB_W'(65536);  // 2^24 >> 8

  // Item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic REG_EPS_INF = 1'b0;
  localparam logic REG_ACTIVE  = 1'b1;

  // Request to the shared divider
  typedef struct packed {
    logic             start;
    logic [SQ_W-1:0]  num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

@@ rtl/debye_div.sv @@
// Iterative fractional divider: quot = floor(num * 2^30 / den) for num <= den.
// Restoring division, two quotient bits per cycle.
// Depends on debye_pkg.
`default_nettype none

module debye_div
  import debye_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire div_req_t        req,
  output logic                 done,
  output logic [Q_W-1:0]       quot
);

  localparam int STEPS = 16;
  localparam int SC_W  = $clog2(STEPS);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [Q_W:0]     q;
  logic [SC_W-1:0]  cnt;
  logic             busy;
  logic             first;

  logic [DEN_W:0]   t1;
  logic [DEN_W:0]   t2;
  logic             b1;
  logic             b2;
  logic [DEN_W-1:0] r1;
  logic [DEN_W-1:0] r2;

  // Two restoring steps; the very first step takes the remainder unshifted
  always_comb begin
    t1 = first ? {1'b0, rem} : {rem, 1'b0};
    b1 = (t1 >= {1'b0, den});
    r1 = b1 ? DEN_W'(t1 - {1'b0, den}) : DEN_W'(t1);
    t2 = {r1, 1'b0};
    b2 = (t2 >= {1'b0, den});
    r2 = b2 ? DEN_W'(t2 - {1'b0, den}) : DEN_W'(t2);
  end

  // Sequence the request
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      first <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem   <= DEN_W'(req.num);
        den   <= req.den;
        busy  <= 1'b1;
        first <= 1'b1;
        cnt   <= '0;
      end else if (busy) begin
        rem   <= r2;
        q     <= {q[Q_W-2:0], b1, b2};
        first <= 1'b0;
        cnt   <= cnt + SC_W'(1);
        if (cnt == SC_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Drop the extra fraction bit
  assign quot = q[Q_W:1];

endmodule

`default_nettype wire

@@ rtl/debye_permittivity_eval_core.sv @@
// Top level of the multi-pole Debye permittivity evaluator.
// Depends on debye_pkg and debye_div.
`default_nettype none

// A load request writes one pole (static permittivity and relaxation code)
// into an eight-entry table. An evaluate request returns the complex
// relative permittivity eps_inf + sum (eps_s - eps_inf)/(1 + jx) over the
// first active_poles poles, saturated to signed Q8.24. Each active pole is
// fetched from the table, scaled in a shift loop, and then goes twice
// through the shared divider, which retires two quotient bits a cycle.
// An evaluation also takes the accept, the final eps_inf add and the load
// of the output register, which also waits while an earlier result is still
// held there. A finished result waits in the output register while the next
// request is taken. Reading a pole that was never loaded gives an undefined
// result. The user must write configuration only while the core is idle;
// the core itself does not enforce this.

module debye_permittivity_eval_core
  import debye_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  // Configuration write port
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [30:0]   cfg_data,
  // Request stream
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata: pole_index[2:0], static_permittivity[33:3], relax_time[65:34],
  //        frequency[97:66], zero pad[103:98]
  input  wire logic [103:0]  s_axis_tdata,
  // tuser: operation[0]
  input  wire logic          s_axis_tuser,
  // Result stream
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // tdata: perm_real[31:0], perm_imag[63:32]
  output logic [63:0]        m_axis_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_MULX, S_PREP, S_NORM, S_SQ, S_DEN,
    S_RE_GO, S_RE_WAIT, S_IM_GO, S_IM_WAIT, S_TERM, S_ACC, S_FINAL, S_OUT
  } state_t;

  localparam int WORD_W = TIME_W + PERM_W;

  state_t state;

  // Configuration
  logic [PERM_W-1:0] eps_inf;
  logic [ACT_W-1:0]  active_poles;

  // Request fields
  logic              in_operation;
  logic [2:0]        in_pole_index;
  logic [PERM_W-1:0] in_static;
  logic [TIME_W-1:0] in_relax;
  logic [FREQ_W-1:0] in_freq;
  logic              accept;

  // Pole memory
  logic [WORD_W-1:0] pole_mem [POLES];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic              mem_re;

  // Evaluation datapath
  logic [FREQ_W-1:0]  freq;
  logic [CNT_W-1:0]   n_lim;
  logic [CNT_W-1:0]   n_poles;
  logic [POLE_IW-1:0] pole;
  logic [X_W-1:0]     x;
  logic [MW_W-1:0]    mw;
  logic [MW_W-1:0]    bw;
  logic [AB_W-1:0]    a;
  logic [SQ_W-1:0]    aa;
  logic [SQ_W-1:0]    ab;
  logic [SQ_W-1:0]    bb;
  logic [DEN_W-1:0]   den;
  logic               dneg;
  logic [PERM_W-1:0]  dmag;
  logic [Q_W-1:0]     ratio_re;
  logic [TERM_W-1:0]  term_re;
  logic [TERM_W-1:0]  term_im;
  logic signed [SUM_W-1:0] sum_re;
  logic signed [SUM_W-1:0] sum_im;

  // Combinational helpers
  logic [63:0]                x_prod;
  logic [X_W-1:0]             x_max;
  logic signed [OUT_W:0]      d_diff;
  logic [OUT_W:0]             d_abs;
  logic [2*AB_W-1:0]          sq_aa;
  logic [2*AB_W-1:0]          sq_ab;
  logic [2*AB_W-1:0]          sq_bb;
  logic [2*Q_W-1:0]           mul_term;
  logic [Q_W-1:0]             mul_ratio;
  logic signed [SUM_W-1:0]    term_re_s;
  logic signed [SUM_W-1:0]    term_im_s;
  logic [OUT_W-1:0]           sat_re;
  logic [OUT_W-1:0]           sat_im;

  div_req_t           div_req;
  logic               div_done;
  logic [Q_W-1:0]     div_quot;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  // Unpack the request
  assign in_operation  = s_axis_tuser;
  assign in_pole_index = s_axis_tdata[2:0];
  assign in_static     = s_axis_tdata[33:3];
  assign in_relax      = s_axis_tdata[65:34];
  assign in_freq       = s_axis_tdata[97:66];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_inf      <= PERM_W'(Q24_ONE);
      active_poles <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EPS_INF: eps_inf      <= cfg_data[PERM_W-1:0];
        REG_ACTIVE:  active_poles <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit the pole count to the table size
  always_comb begin
    if (32'(active_poles) > POLES) begin
      n_lim = CNT_W'(POLES);
    end else begin
      n_lim = CNT_W'(active_poles);
    end
  end

  // Pole table: one write and one registered read per cycle
  assign mem_we = accept && (in_operation == OP_LOAD) && (32'(in_pole_index) < POLES);
  assign mem_re = (state == S_FETCH);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pole_mem[POLE_IW'(in_pole_index)] <= {in_relax, in_static};
    end
    if (mem_re) begin
      rd_data <= pole_mem[pole];
    end
  end

  // Datapath arithmetic
  always_comb begin
    x_prod    = 64'(freq) * 64'(rd_data[WORD_W-1:PERM_W]);
    x_max     = (x > Q24_ONE) ? x : Q24_ONE;
    d_diff    = $signed({2'b0, rd_data[PERM_W-1:0]}) - $signed({2'b0, eps_inf});
    d_abs     = d_diff[OUT_W] ? (OUT_W+1)'(0) - d_diff : d_diff;
    sq_aa     = (2*AB_W)'(a) * (2*AB_W)'(a);
    sq_ab     = (2*AB_W)'(a) * (2*AB_W)'(bw[AB_W-1:0]);
    sq_bb     = (2*AB_W)'(bw[AB_W-1:0]) * (2*AB_W)'(bw[AB_W-1:0]);
    mul_ratio = (state == S_IM_GO) ? ratio_re : div_quot;
    mul_term  = (2*Q_W)'(dmag) * (2*Q_W)'(mul_ratio);
    term_re_s = $signed({{(SUM_W-TERM_W){1'b0}}, term_re});
    term_im_s = $signed({{(SUM_W-TERM_W){1'b0}}, term_im});
  end

  // Start the shared divider on the real, then the imaginary ratio
  always_comb begin
    div_req.start = (state == S_RE_GO) || (state == S_IM_GO);
    div_req.num   = (state == S_IM_GO) ? ab : aa;
    div_req.den   = den;
  end

  debye_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // Saturate both sums to the output range
  always_comb begin
    if (sum_re > SAT_MAX) begin
      sat_re = OUT_W'(SAT_MAX);
    end else if (sum_re < SAT_MIN) begin
      sat_re = OUT_W'(SAT_MIN);
    end else begin
      sat_re = sum_re[OUT_W-1:0];
    end
    if (sum_im > SAT_MAX) begin
      sat_im = OUT_W'(SAT_MAX);
    end else if (sum_im < SAT_MIN) begin
      sat_im = OUT_W'(SAT_MIN);
    end else begin
      sat_im = sum_im[OUT_W-1:0];
    end
  end

  // Sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      pole          <= '0;
    end else begin
      // Raise valid when a result is loaded, drop it once taken
      if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (in_operation == OP_EVAL)) begin
            freq    <= in_freq;
            n_poles <= n_lim;
            pole    <= '0;
            sum_re  <= '0;
            sum_im  <= '0;
            state   <= (n_lim == '0) ? S_FINAL : S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_MULX;
        end
        S_MULX: begin
          x     <= x_prod[63:24];
          dneg  <= d_diff[OUT_W];
          dmag  <= d_abs[PERM_W-1:0];
          state <= S_PREP;
        end
        S_PREP: begin
          mw    <= x_max[X_W-1:8];
          bw    <= x[X_W-1:8];
          a     <= A_START;
          state <= S_NORM;
        end
        S_NORM: begin
          // Shift until the larger operand fits the scale limit
          if (mw > SCALE_LIMIT) begin
            if ((mw >> 4) > SCALE_LIMIT) begin
              mw <= mw >> 4;
              bw <= bw >> 4;
              a  <= a >> 4;
            end else begin
              mw <= mw >> 1;
              bw <= bw >> 1;
              a  <= a >> 1;
            end
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          aa    <= sq_aa[SQ_W-1:0];
          ab    <= sq_ab[SQ_W-1:0];
          bb    <= sq_bb[SQ_W-1:0];
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= {1'b0, aa} + {1'b0, bb};
          state <= S_RE_GO;
        end
        S_RE_GO: begin
          state <= S_RE_WAIT;
        end
        S_RE_WAIT: begin
          if (div_done) begin
            ratio_re <= div_quot;
            state    <= S_IM_GO;
          end
        end
        S_IM_GO: begin
          term_re <= mul_term[TERM_W+30-1:30];
          state   <= S_IM_WAIT;
        end
        S_IM_WAIT: begin
          if (div_done) begin
            term_im <= mul_term[TERM_W+30-1:30];
            state   <= S_TERM;
          end
        end
        S_TERM: begin
          sum_re <= dneg ? sum_re - term_re_s : sum_re + term_re_s;
          state  <= S_ACC;
        end
        S_ACC: begin
          sum_im <= dneg ? sum_im + term_im_s : sum_im - term_im_s;
          if (CNT_W'(pole) + CNT_W'(1) == n_poles) begin
            state <= S_FINAL;
          end else begin
            pole  <= pole + POLE_IW'(1);
            state <= S_FETCH;
          end
        end
        S_FINAL: begin
          sum_re <= sum_re + $signed({{(SUM_W-PERM_W){1'b0}}, eps_inf});
          state  <= S_OUT;
        end
        S_OUT: begin
          // Load the result once the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {sat_im, sat_re};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Divider completes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_RE_WAIT || state == S_IM_WAIT))
    else $error("divider finished outside a wait state");

  // Normalized operands are within the scale limit and ordered
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> (mw <= SCALE_LIMIT && bw <= mw && a != '0))
    else $error("normalization left operands out of range");

  // Fetched pole lies within the active count
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (CNT_W'(pole) < n_poles))
    else $error("pole fetch beyond active count");

  // An evaluate request starts the pole walk or goes straight to the final add
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_operation == OP_EVAL) |=> (state == S_FETCH || state == S_FINAL))
    else $error("evaluate request did not start");

endmodule

`default_nettype wire

@@ dv/debye_permittivity_eval_core_tb.sv @@
// Self-checking testbench for debye_permittivity_eval_core: a directed table, then random
// load and evaluate requests, scored against an in-bench Debye predictor or fixed values.
// Depends on debye_pkg and the core RTL only.

module debye_permittivity_eval_core_tb;
  import debye_pkg::*;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int NO_IDLE_TAIL   = 150;
  localparam int SETTLE_CYCLES  = 420;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [30:0] PERM_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] PERM_ONE = 31'd16777216;
  localparam longint      OUT_MAX  = 64'sd2147483647;
  localparam longint      OUT_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic              op;
    logic [2:0]        idx;
    logic [30:0]       eps_s;
    logic [31:0]       tau;
    logic [31:0]       freq;
  } request_t;

  typedef struct packed {
    logic [31:0] re_part;
    logic [31:0] im_part;
  } perm_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        reg_idx;
    logic [30:0] reg_val;
    request_t    req;
    bit          typed;
    perm_t       want;
  } plan_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic          cfg_index = REG_EPS_INF;
  logic [30:0]   cfg_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  // tdata: pole_index[2:0], static_permittivity[33:3], relax_time[65:34],
  //        frequency[97:66], zero pad[103:98]
  logic [103:0]  s_axis_tdata = '0;
  // tuser: operation[0]
  logic          s_axis_tuser = OP_LOAD;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b1;
  // tdata: perm_real[31:0], perm_imag[63:32]
  logic [63:0]   m_axis_tdata;

  // Predictor state: pole table and configuration as the core should hold them
  logic [30:0]   static_perm_tab [POLES];
  logic [31:0]   relax_code_tab [POLES];
  logic [30:0]   eps_inf_reg = PERM_ONE;
  logic [3:0]    active_reg = '0;

  perm_t         perm_expected_q [$];
  plan_row_t     directed_plan [$];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  int            stall_left = 0;
  bit            idle_on = 1'b1;

  always #1 clk = ~clk;

  debye_permittivity_eval_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Signed magnitude times a Q0.30 ratio, truncated toward zero
  function automatic longint scaled_share(longint d, bit [63:0] ratio);
    bit [63:0] mag;
    bit [63:0] prod;
    mag  = (d < 0) ? 64'(-d) : 64'(d);
    prod = (mag * ratio) >> 30;
    return (d < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > OUT_MAX) return 32'h7FFF_FFFF;
    if (v < OUT_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Complex relative permittivity at one frequency over the active poles
  function automatic perm_t debye_response(logic [31:0] freq);
    bit [63:0] x, m, a, b, den, ratio_re, ratio_im;
    longint    sum_re, sum_im, d;
    int        n, sh, p;
    perm_t     res;
    sum_re = 0;
    sum_im = 0;
    n = (active_reg > POLES) ? POLES : int'(active_reg);
    for (p = 0; p < n; p++) begin
      x = (64'(freq) * 64'(relax_code_tab[p])) >> 24;
      m = (x > 64'(Q24_ONE)) ? x : 64'(Q24_ONE);
      sh = 0;
      while ((m >> sh) > 64'(SCALE_LIMIT)) sh++;
      a = 64'(Q24_ONE) >> sh;
      b = x >> sh;
      den = a * a + b * b;
      ratio_re = ((a * a) << 30) / den;
      ratio_im = ((a * b) << 30) / den;
      d = longint'({33'd0, static_perm_tab[p]}) - longint'({33'd0, eps_inf_reg});
      sum_re += scaled_share(d, ratio_re);
      sum_im -= scaled_share(d, ratio_im);
    end
    sum_re += longint'({33'd0, eps_inf_reg});
    res.re_part = clip32(sum_re);
    res.im_part = clip32(sum_im);
    return res;
  endfunction

  function automatic void plan_item(logic op, logic [2:0] idx, logic [30:0] eps_s,
                                    logic [31:0] tau, logic [31:0] freq, bit typed = 1'b0,
                                    logic [31:0] want_re = '0, logic [31:0] want_im = '0);
    plan_row_t row;
    row.kind         = ROW_REQUEST;
    row.reg_idx      = REG_EPS_INF;
    row.reg_val      = '0;
    row.req.op       = op;
    row.req.idx      = idx;
    row.req.eps_s    = eps_s;
    row.req.tau      = tau;
    row.req.freq     = freq;
    row.typed        = typed;
    row.want.re_part = want_re;
    row.want.im_part = want_im;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_write(logic idx, logic [30:0] val);
    plan_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    row.req     = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_plan.push_back(row);
  endfunction

  // Wide operand: extremes, full random, or random with a random number of leading zeros
  function automatic logic [31:0] draw_wide();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic request_t draw_request();
    request_t r;
    r.op   = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_EVAL;
    r.idx  = 3'($urandom_range(0, POLES - 1));
    r.tau  = draw_wide();
    r.freq = draw_wide();
    case ($urandom_range(0, 5))
      0: r.eps_s = '0;
      1: r.eps_s = PERM_MAX;
      2: r.eps_s = (eps_inf_reg > 31'h7F00_0000) ? eps_inf_reg - 31'($urandom_range(0, 1 << 20))
                                                 : eps_inf_reg + 31'($urandom_range(0, 1 << 20));
      3: r.eps_s = 31'($urandom_range(1, 80)) << 24;
      default: r.eps_s = 31'($urandom);
    endcase
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_EPS_INF) eps_inf_reg = val;
    else active_reg = val[3:0];
    @(posedge clk);
  endtask

  // Drop valid, wait for every result, then let any trailing work finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (perm_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Present one request, hold it until taken, then update the predictor
  task automatic issue_request(request_t r, bit typed, perm_t want);
    perm_t predicted;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {6'd0, r.freq, r.tau, r.eps_s, r.idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (r.op == OP_LOAD) begin
      static_perm_tab[r.idx] = r.eps_s;
      relax_code_tab[r.idx]  = r.tau;
    end else begin
      predicted = debye_response(r.freq);
      perm_expected_q.push_back(typed ? want : predicted);
    end
  endtask

  // Result sink with random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 17);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    perm_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (perm_expected_q.size() == 0) begin
        $error("unexpected result: perm_real %h perm_imag %h",
               m_axis_tdata[31:0], m_axis_tdata[63:32]);
        mismatches++;
      end else begin
        want = perm_expected_q.pop_front();
        if (m_axis_tdata[31:0] !== want.re_part) begin
          $error("perm_real: expected %h, actual %h", want.re_part, m_axis_tdata[31:0]);
          mismatches++;
        end
        if (m_axis_tdata[63:32] !== want.im_part) begin
          $error("perm_imag: expected %h, actual %h", want.im_part, m_axis_tdata[63:32]);
          mismatches++;
        end
      end
    end
  end

  // End the run if neither a request nor a result moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("debye_permittivity_eval_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int        i;
    int        random_sent;
    int        remaining;
    int        phase_len;
    logic [30:0] eps_pick;
    logic [3:0]  active_pick;
    request_t  r;
    perm_t     no_want;

    no_want = '0;
    random_sent = 0;

    // Reset values: eps_inf 1.0, no active poles, so evaluation returns (eps_inf, 0)
    plan_item(OP_EVAL, 3'd0, '0, '0, '0, 1'b1, 32'd16777216, 32'd0);
    plan_item(OP_EVAL, 3'd7, PERM_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              32'd16777216, 32'd0);
    // All poles at maximum static permittivity, x = freq >> 0 at tau 1.0
    for (i = 0; i < POLES; i++)
      plan_item(OP_LOAD, 3'(i), PERM_MAX, 32'd16777216, 32'($urandom));
    plan_write(REG_EPS_INF, '0);
    plan_write(REG_ACTIVE, 31'd8);
    // Zero frequency: each pole adds its full step, real part saturates high
    plan_item(OP_EVAL, 3'd0, '0, '0, 32'd0, 1'b1, 32'h7FFF_FFFF, 32'd0);
    // x = 1.0 on every pole: real saturates high, imaginary saturates low
    plan_item(OP_EVAL, 3'd0, '0, '0, 32'd16777216, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    plan_write(REG_ACTIVE, 31'd1);
    plan_item(OP_EVAL, 3'd5, PERM_MAX, 32'hFFFF_FFFF, 32'd16777216);
    plan_write(REG_EPS_INF, PERM_MAX);
    plan_write(REG_ACTIVE, 31'd0);
    plan_item(OP_EVAL, 3'd0, '0, '0, 32'd5, 1'b1, 32'h7FFF_FFFF, 32'd0);
    // All poles at zero static permittivity, longest relaxation code
    for (i = 0; i < POLES; i++)
      plan_item(OP_LOAD, 3'(i), '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Active count above the table size clamps to all poles
    plan_write(REG_ACTIVE, 31'd15);
    plan_item(OP_EVAL, 3'd0, '0, '0, 32'd0, 1'b1, 32'h8000_0000, 32'd0);
    plan_item(OP_EVAL, 3'd2, '0, '0, 32'd65536);
    plan_item(OP_EVAL, 3'd0, '0, '0, 32'hFFFF_FFFF);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_plan[k].reg_idx, directed_plan[k].reg_val);
      end else begin
        issue_request(directed_plan[k].req, directed_plan[k].typed, directed_plan[k].want);
      end
    end

    // Random phases, each under its own configuration
    while (random_sent < RANDOM_ITEMS) begin
      remaining = RANDOM_ITEMS - random_sent;
      settle();
      case ($urandom_range(0, 5))
        0: eps_pick = '0;
        1: eps_pick = PERM_MAX;
        2: eps_pick = PERM_ONE;
        3: eps_pick = 31'($urandom_range(1, 80)) << 24;
        default: eps_pick = 31'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: active_pick = 4'd0;
        1: active_pick = 4'd8;
        2: active_pick = 4'($urandom_range(9, 15));
        default: active_pick = 4'($urandom_range(1, 4));
      endcase
      write_reg(REG_EPS_INF, eps_pick);
      write_reg(REG_ACTIVE, 31'(active_pick));
      idle_on = (remaining > NO_IDLE_TAIL) && ($urandom_range(0, 4) != 0);
      phase_len = $urandom_range(30, 90);
      if (phase_len > remaining) phase_len = remaining;
      for (i = 0; i < phase_len; i++) begin
        r = draw_request();
        issue_request(r, 1'b0, no_want);
      end
      random_sent += phase_len;
    end

    settle();
    if (mismatches == 0 && perm_expected_q.size() == 0) begin
      $display("debye_permittivity_eval_core_tb OK");
    end else begin
      $display("debye_permittivity_eval_core_tb NOT OK");
    end
    $finish;
  end

endmodule
